### hdl/motor_speed_pd_controller_unit_defines.svh
// Assertion macros shared by the speed controller RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef MOTOR_SPEED_PD_CONTROLLER_UNIT_DEFINES_SVH
`define MOTOR_SPEED_PD_CONTROLLER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSPD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("speed controller check failed");

// The consequent must hold in the cycle after the antecedent.
`define MSPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("speed controller check failed");

`endif

### hdl/mspd_pkg.sv
// Shared types and constants for the motor speed PD controller.
// No dependencies; used by every module of the block.
package mspd_pkg;

    // Plan codes.
    localparam logic [1:0] PLAN_FAST_FIXED = 2'd0;
    localparam logic [1:0] PLAN_SLOW_FIXED = 2'd1;
    localparam logic [1:0] PLAN_RULES_A    = 2'd2;
    localparam logic [1:0] PLAN_RULES_B    = 2'd3;
    localparam logic [1:0] PLAN_RESET      = PLAN_SLOW_FIXED;

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-1:0] PLAN_ADDR = 3'd0;

    // Widths.
    localparam int SPEED_W  = 10;
    localparam int TARGET_W = 7;
    localparam int KP_W     = 7;
    localparam int KD_W     = 5;
    localparam int ERR_W    = 11;
    localparam int DIFF_W   = 12;
    localparam int SUM_W    = 19;
    localparam int DRIVE_W  = 13;
    localparam int DUTY_W   = 12;

    // Drive shaping.
    localparam logic signed [SUM_W-1:0] DRIVE_BIAS = 19'sd1200;
    localparam logic signed [SUM_W-1:0] DRIVE_MAX  = 19'sd4000;
    localparam logic signed [SUM_W-1:0] DRIVE_MIN  = -19'sd3000;

    // Rule thresholds.
    localparam logic [16:0] STEER_DRIVE_LIMIT = 17'd600;
    localparam logic [15:0] NEAR_DISTANCE     = 16'd100;
    localparam logic [11:0] LEVEL_LIMIT       = 12'd2000;
    localparam logic [3:0]  RING_ENTRY_A      = 4'd3;
    localparam logic [3:0]  RING_ENTRY_B      = 4'd4;

    // Target speed and gains chosen for one tick.
    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [KP_W-1:0]     kp;
        logic [KD_W-1:0]     kd;
    } gain_t;

    // One result item.
    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic [DUTY_W-1:0]  forward_duty;
        logic [DUTY_W-1:0]  reverse_duty;
    } result_t;

endpackage

### hdl/mspd_target.sv
// Target speed and PD gain selection from the plan and track-condition inputs.
// Depends on mspd_pkg.
module mspd_target
(
    input  logic [1:0]         plan,
    input  logic signed [7:0]  steer_error,
    input  logic               break_flag,
    input  logic signed [15:0] steer_drive,
    input  logic [15:0]        obstacle_distance,
    input  logic [2:0]         obstacle_state,
    input  logic [3:0]         ring_state,
    input  logic               ramp_flag,
    input  logic [11:0]        left_level,
    input  logic [11:0]        right_level,
    output mspd_pkg::gain_t    gains
);

    logic [8:0]                    err_mag;
    logic [16:0]                   drv_mag;
    logic                          rules_a;
    logic [mspd_pkg::TARGET_W-1:0] rule_target;

    // Magnitudes of the steering error and the steering drive.
    assign err_mag = steer_error[7] ? 9'(-{steer_error[7], steer_error})
                                    : {1'b0, steer_error};
    assign drv_mag = steer_drive[15] ? 17'(-{steer_drive[15], steer_drive})
                                     : {1'b0, steer_drive};
    assign rules_a = (plan == mspd_pkg::PLAN_RULES_A);

    // The last rule that holds wins, so the rules are checked from last to first.
    always_comb
    begin
        priority if ((left_level > mspd_pkg::LEVEL_LIMIT) ||
                     (right_level > mspd_pkg::LEVEL_LIMIT))
            rule_target = 7'd3;
        else if (ramp_flag)
            rule_target = 7'd7;
        else if ((ring_state == mspd_pkg::RING_ENTRY_A) ||
                 (ring_state == mspd_pkg::RING_ENTRY_B))
            rule_target = 7'd5;
        else if (ring_state != 4'd0)
            rule_target = rules_a ? 7'd7 : 7'd10;
        else if (obstacle_state != 3'd0)
            rule_target = rules_a ? 7'd7 : 7'd10;
        else if (obstacle_distance < mspd_pkg::NEAR_DISTANCE)
            rule_target = 7'd5;
        else if (rules_a && break_flag && (drv_mag > mspd_pkg::STEER_DRIVE_LIMIT))
            rule_target = 7'd7;
        else if (break_flag)
            rule_target = 7'd15;
        else if (rules_a && (err_mag >= 9'd15))
            rule_target = 7'd15;
        else if (err_mag >= 9'd10)
            rule_target = rules_a ? 7'd25 : 7'd30;
        else if (err_mag >= 9'd3)
            rule_target = 7'd35;
        else if (err_mag >= 9'd2)
            rule_target = 7'd40;
        else if (err_mag >= 9'd1)
            rule_target = 7'd45;
        else
            rule_target = 7'd60;
    end

    // Fixed plans use constant settings; the rule plans share one gain pair.
    always_comb
    begin
        unique case (plan)
            mspd_pkg::PLAN_FAST_FIXED:
            begin
                gains.target = 7'd15;
                gains.kp     = 7'd70;
                gains.kd     = 5'd20;
            end
            mspd_pkg::PLAN_SLOW_FIXED:
            begin
                gains.target = 7'd10;
                gains.kp     = 7'd60;
                gains.kd     = 5'd10;
            end
            default:
            begin
                gains.target = rule_target;
                gains.kp     = 7'd80;
                gains.kd     = 5'd30;
            end
        endcase
    end

endmodule

### hdl/mspd_pd_calc.sv
// Speed error, PD drive law, clamp and duty split for one tick.
// Depends on mspd_pkg.
module mspd_pd_calc
(
    input  mspd_pkg::gain_t                   gains,
    input  logic signed [mspd_pkg::SPEED_W-1:0] measured_speed,
    input  logic signed [mspd_pkg::ERR_W-1:0]   previous_error,
    output logic signed [mspd_pkg::ERR_W-1:0]   speed_error,
    output mspd_pkg::result_t                  result
);

    logic signed [mspd_pkg::DIFF_W-1:0] err_diff;
    logic signed [mspd_pkg::SUM_W-1:0]  p_term;
    logic signed [mspd_pkg::SUM_W-1:0]  d_term;
    logic signed [mspd_pkg::SUM_W-1:0]  drive_sum;
    logic signed [mspd_pkg::SUM_W-1:0]  drive_clamped;
    logic signed [mspd_pkg::SUM_W-1:0]  drive_neg;

    // Error against the target; it always fits the stored error width.
    assign speed_error = $signed({4'b0, gains.target}) - 11'(measured_speed);
    assign err_diff    = 12'(speed_error) - 12'(previous_error);

    // Proportional and derivative terms plus the bias.
    assign p_term    = $signed(19'({1'b0, gains.kp})) * 19'(speed_error);
    assign d_term    = $signed(19'({1'b0, gains.kd})) * 19'(err_diff);
    assign drive_sum = p_term + d_term + mspd_pkg::DRIVE_BIAS;

    // Clamp to the allowed drive range.
    always_comb
    begin
        priority if (drive_sum > mspd_pkg::DRIVE_MAX)
            drive_clamped = mspd_pkg::DRIVE_MAX;
        else if (drive_sum < mspd_pkg::DRIVE_MIN)
            drive_clamped = mspd_pkg::DRIVE_MIN;
        else
            drive_clamped = drive_sum;
    end

    assign drive_neg = -drive_clamped;

    // Split into forward and reverse duty.
    assign result.drive        = drive_clamped[mspd_pkg::DRIVE_W-1:0];
    assign result.forward_duty = drive_clamped[mspd_pkg::SUM_W-1] ? '0
                               : drive_clamped[mspd_pkg::DUTY_W-1:0];
    assign result.reverse_duty = drive_clamped[mspd_pkg::SUM_W-1]
                               ? drive_neg[mspd_pkg::DUTY_W-1:0] : '0;

endmodule

### hdl/motor_speed_pd_controller_unit.sv
// Motor speed PD controller: one item is one control tick. The block takes an item in every
// cycle unless a stalled result blocks it; the item is registered, and in the next cycle the
// target, gains, error and drive are formed and, on every UPDATE_PERIOD-th item, written to
// the result register. Throughput is one item per cycle while no result is stalled, and one
// result per UPDATE_PERIOD items; a stalled result holds only the item that would produce the
// next result. The plan register sits on the APB port at byte address 0 and resets to 1.
// Depends on mspd_pkg, mspd_target, mspd_pd_calc and the assertion macro header.
`include "motor_speed_pd_controller_unit_defines.svh"

module motor_speed_pd_controller_unit
#(
    parameter int UPDATE_PERIOD = 5
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mspd_pkg::ADDR_W-1:0]   paddr,
    input  logic [mspd_pkg::DATA_W-1:0]   pwdata,
    output logic [mspd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,

    // Input items.
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [9:0]             measured_speed,
    input  logic signed [7:0]             steer_error,
    input  logic                          break_flag,
    input  logic signed [15:0]            steer_drive,
    input  logic [15:0]                   obstacle_distance,
    input  logic [2:0]                    obstacle_state,
    input  logic [3:0]                    ring_state,
    input  logic                          ramp_flag,
    input  logic [11:0]                   left_level,
    input  logic [11:0]                   right_level,

    // Result items.
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [12:0]            drive,
    output logic [11:0]                   forward_duty,
    output logic [11:0]                   reverse_duty
);

    localparam int TICK_W = $clog2(UPDATE_PERIOD + 1);

    // Configuration.
    logic [1:0] plan_reg;
    logic       plan_write;

    // Input register.
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic signed [9:0]  speed_reg;
    logic signed [7:0]  steer_error_reg;
    logic               break_flag_reg;
    logic signed [15:0] steer_drive_reg;
    logic [15:0]        distance_reg;
    logic [2:0]         obstacle_reg;
    logic [3:0]         ring_reg;
    logic               ramp_reg;
    logic [11:0]        left_reg;
    logic [11:0]        right_reg;

    // Controller state.
    logic signed [mspd_pkg::ERR_W-1:0] prev_err_reg;
    logic [TICK_W-1:0]                 tick_count_reg;
    logic [TICK_W:0]                   tick_inc;
    logic                              emit;

    // Result register.
    logic                 out_valid_reg;
    logic                 out_valid_next;
    mspd_pkg::result_t    result_reg;

    // Stage wiring.
    mspd_pkg::gain_t                   gains;
    mspd_pkg::result_t                 calc_result;
    logic signed [mspd_pkg::ERR_W-1:0] speed_error;
    logic                              in_accept;
    logic                              out_free;
    logic                              s1_fire;

    // APB register access.
    assign pready     = 1'b1;
    assign plan_write = psel && penable && pwrite && pready &&
                        (paddr == mspd_pkg::PLAN_ADDR);
    assign prdata     = (paddr == mspd_pkg::PLAN_ADDR) ? {30'b0, plan_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            plan_reg <= mspd_pkg::PLAN_RESET;
        else if (plan_write)
            plan_reg <= pwdata[1:0];
    end

    // Tick counting: a result is due when the incremented count reaches the period.
    assign tick_inc = {1'b0, tick_count_reg} + (TICK_W+1)'(1);
    assign emit     = (tick_inc >= (TICK_W+1)'(UPDATE_PERIOD));

    // Flow control: the registered item moves on unless it makes a result with no room.
    assign out_free  = !out_valid_reg || out_ready;
    assign s1_fire   = s1_valid_reg && (!emit || out_free);
    assign in_ready  = !s1_valid_reg || s1_fire;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire && emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_err_reg   <= '0;
            tick_count_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                prev_err_reg   <= speed_error;
                tick_count_reg <= emit ? '0 : tick_inc[TICK_W-1:0];
            end
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            speed_reg       <= measured_speed;
            steer_error_reg <= steer_error;
            break_flag_reg  <= break_flag;
            steer_drive_reg <= steer_drive;
            distance_reg    <= obstacle_distance;
            obstacle_reg    <= obstacle_state;
            ring_reg        <= ring_state;
            ramp_reg        <= ramp_flag;
            left_reg        <= left_level;
            right_reg       <= right_level;
        end
    end

    // Target and gain selection.
    mspd_target u_target
    (
        .plan              (plan_reg),
        .steer_error       (steer_error_reg),
        .break_flag        (break_flag_reg),
        .steer_drive       (steer_drive_reg),
        .obstacle_distance (distance_reg),
        .obstacle_state    (obstacle_reg),
        .ring_state        (ring_reg),
        .ramp_flag         (ramp_reg),
        .left_level        (left_reg),
        .right_level       (right_reg),
        .gains             (gains)
    );

    // PD law and drive split.
    mspd_pd_calc u_pd_calc
    (
        .gains          (gains),
        .measured_speed (speed_reg),
        .previous_error (prev_err_reg),
        .speed_error    (speed_error),
        .result         (calc_result)
    );

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (s1_fire && emit)
            result_reg <= calc_result;
    end

    assign out_valid    = out_valid_reg;
    assign drive        = $signed(result_reg.drive);
    assign forward_duty = result_reg.forward_duty;
    assign reverse_duty = result_reg.reverse_duty;

    // Checks on the result path and the tick counter.
    `MSPD_ASSERT_SAME(a_tick_in_range, 1'b1, tick_count_reg < TICK_W'(UPDATE_PERIOD))
    `MSPD_ASSERT_NEXT(a_emit_loads_result, s1_fire && emit, out_valid_reg)
    `MSPD_ASSERT_SAME(a_drive_in_range, out_valid_reg,
        (drive >= -13'sd3000) && (drive <= 13'sd4000))
    `MSPD_ASSERT_SAME(a_duty_matches_drive, out_valid_reg,
        (13'(forward_duty) - 13'(reverse_duty)) == 13'(drive))

endmodule
